FILE: sv/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg: shared types and constants for the generational handle pool
// Slot geometry, request and status codes, and the transaction payloads.
// ----------------------------------------------------------------------------
package ghp_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int GEN_W      = 32;

  typedef logic [IDX_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [GEN_W-1:0] gen_t;

  // request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RECYCLE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP  = 2'd2;
  localparam logic [1:0] REQ_MAKE    = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_STALE    = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] slot_index;
    logic [31:0] in_generation;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_index;
    logic [31:0] out_generation;
  } result_t;

  // A free-stack entry carries the slot's generation along, so an alloc
  // gets its handle without a second lookup.
  typedef struct packed {
    slot_idx_t slot;
    gen_t      gen;
  } stack_entry_t;

  typedef struct packed {
    logic         pop;
    logic         push;
    stack_entry_t push_entry;
  } stack_ctl_t;

  typedef struct packed {
    logic      we;
    slot_idx_t addr;
    gen_t      data;
  } gen_wr_t;

  // Post-reset stack contents: slot 0 on top, so position p holds slot N-1-p.
  function automatic stack_entry_t stack_reset_entry(slot_idx_t pos);
    stack_entry_t e;
    e.slot = IDX_W'(SLOT_COUNT - 1) - pos;
    e.gen  = GEN_W'(1);
    return e;
  endfunction

endpackage

FILE: sv/ghp_gen_ram.sv
// ----------------------------------------------------------------------------
// ghp_gen_ram: per-slot generation store
// One write and one registered read per cycle. Valid bits stand in for the
// reset value of one; a same-cycle write is forwarded to the read.
// ----------------------------------------------------------------------------
module ghp_gen_ram
  import ghp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  gen_wr_t   wr,
  input  logic      rd_en,
  input  slot_idx_t rd_addr,
  output gen_t      rd_data_r
);

  gen_t                  mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= GEN_W'(1);
      end
    end
  end

endmodule

FILE: sv/ghp_free_stack.sv
// ----------------------------------------------------------------------------
// ghp_free_stack: LIFO of free slots
// Holds the fill count and prefetches the entry that will be on top once the
// current push or pop has landed, so the next alloc finds it registered.
// ----------------------------------------------------------------------------
module ghp_free_stack
  import ghp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  stack_ctl_t   ctl,
  input  logic         rd_en,
  output cnt_t         count_r,
  output stack_entry_t top_r
);

  stack_entry_t          mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;
  cnt_t                  count_nxt;
  slot_idx_t             wr_ptr;
  slot_idx_t             rd_addr;
  logic                  push_ok;
  logic                  pop_ok;

  assign wr_ptr  = count_r[IDX_W-1:0];
  assign push_ok = ctl.push && (count_r < CNT_W'(SLOT_COUNT));
  assign pop_ok  = ctl.pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // top after this cycle's update; wraps harmlessly when the stack drains
  assign rd_addr = IDX_W'(count_nxt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= ctl.push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      count_r <= CNT_W'(SLOT_COUNT);
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        vld_r[wr_ptr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (push_ok && (wr_ptr == rd_addr)) begin
        top_r <= ctl.push_entry;
      end else if (vld_r[rd_addr]) begin
        top_r <= mem[rd_addr];
      end else begin
        top_r <= stack_reset_entry(rd_addr);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("free stack count above slot count");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (count_r != '0))
    else $error("pop issued on empty free stack");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.pop && (count_r < CNT_W'(SLOT_COUNT)))
      |=> (count_r == cnt_t'($past(count_r) + CNT_W'(1))))
    else $error("push did not grow the free stack");
`endif

endmodule

FILE: sv/generational_handle_pool_top.sv
// ----------------------------------------------------------------------------
// generational_handle_pool_top: slot pool handing out generational handles
// Alloc, recycle, lookup and make-handle requests over a 64-slot pool.
// ----------------------------------------------------------------------------
// One request is accepted per clock while out_ready does not stall the result
// path, and each gives exactly one result: the generation and free-stack reads
// are registered at acceptance, the request is resolved in the execute register,
// and the result sits in an output register, which lets the next request enter
// while a result still waits. After reset the pool is ready at once: valid bits
// supply the initial generations and stack contents, so no clearing pass runs.
// Recycling a slot that is not allocated returns status 4 and changes nothing.
// ----------------------------------------------------------------------------
module generational_handle_pool_top
  import ghp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  req_t    in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic                  ex_valid_r;
  req_t                  ex_req_r;
  logic                  out_valid_r;
  result_t               out_data_r;
  logic [SLOT_COUNT-1:0] slot_in_use_r;
  logic [SLOT_COUNT-1:0] slot_in_use_nxt;

  logic         ex_fire;
  logic         in_fire;
  gen_t         gen_rd;
  stack_entry_t top;
  cnt_t         free_count;
  stack_ctl_t   stk_ctl;
  gen_wr_t      gen_wr;
  result_t      res;
  slot_idx_t    sidx;
  logic         range_bad;
  gen_t         gen_inc;
  logic         do_alloc;
  logic         do_recycle;

  assign ex_fire  = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ex_valid_r || ex_fire;
  assign in_fire  = in_valid && in_ready;

  ghp_gen_ram u_gen_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (gen_wr),
    .rd_en     (in_fire),
    .rd_addr   (in_data.slot_index[IDX_W-1:0]),
    .rd_data_r (gen_rd)
  );

  ghp_free_stack u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (stk_ctl),
    .rd_en   (in_fire),
    .count_r (free_count),
    .top_r   (top)
  );

  assign sidx      = ex_req_r.slot_index[IDX_W-1:0];
  assign range_bad = ex_req_r.slot_index >= 32'(SLOT_COUNT);
  assign gen_inc   = gen_rd + GEN_W'(1);

  always_comb begin
    res        = '0;
    do_alloc   = 1'b0;
    do_recycle = 1'b0;
    unique case (ex_req_r.req_type)
      REQ_ALLOC: begin
        if (free_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status         = ST_OK;
          res.out_index      = 6'(top.slot);
          res.out_generation = top.gen;
          do_alloc           = 1'b1;
        end
      end
      REQ_RECYCLE: begin
        if (range_bad) begin
          res.status = ST_RANGE;
        end else if (!slot_in_use_r[sidx]) begin
          res.status         = ST_NOTALLOC;
          res.out_index      = 6'(sidx);
          res.out_generation = gen_rd;
        end else begin
          res.status         = ST_OK;
          res.out_index      = 6'(sidx);
          res.out_generation = gen_inc;
          do_recycle         = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (range_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.status         = (gen_rd != ex_req_r.in_generation) ? ST_STALE : ST_OK;
          res.out_index      = 6'(sidx);
          res.out_generation = gen_rd;
        end
      end
      REQ_MAKE: begin
        if (range_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.status         = ST_OK;
          res.out_index      = 6'(sidx);
          res.out_generation = gen_rd;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    stk_ctl.pop             = ex_fire && do_alloc;
    stk_ctl.push            = ex_fire && do_recycle;
    stk_ctl.push_entry.slot = sidx;
    stk_ctl.push_entry.gen  = gen_inc;
    gen_wr.we               = ex_fire && do_recycle;
    gen_wr.addr             = sidx;
    gen_wr.data             = gen_inc;
  end

  always_comb begin
    slot_in_use_nxt = slot_in_use_r;
    if (ex_fire && do_alloc) begin
      slot_in_use_nxt[top.slot] = 1'b1;
    end
    if (ex_fire && do_recycle) begin
      slot_in_use_nxt[sidx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      slot_in_use_r <= '0;
    end else begin
      slot_in_use_r <= slot_in_use_nxt;
      if (in_ready) begin
        ex_valid_r <= in_valid;
      end
      if (ex_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_req_r <= in_data;
    end
    if (ex_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_pop_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && do_alloc) |-> !slot_in_use_r[top.slot])
    else $error("free stack handed out a slot already in use");

  a_slot_census: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(slot_in_use_r) + int'(free_count)) == SLOT_COUNT)
    else $error("in-use slots plus free count differ from pool size");

  a_lookup_ok_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && (ex_req_r.req_type == REQ_LOOKUP) && (res.status == ST_OK))
      |-> (res.out_generation == ex_req_r.in_generation))
    else $error("lookup answered ok with a mismatched generation");
`endif

endmodule
